### rtl/core/byte_ring_fifo_top_defines.svh
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shared concurrent assertion forms for the byte ring FIFO RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFIFO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFIFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bfifo_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Request codes, payload types and fixed widths shared by the FIFO RTL.
// ----------------------------------------------------------------------------
package bfifo_pkg;

    // Width of size, fill, free space and request lengths.
    localparam int SW = 11;
    // Width of one stored byte.
    localparam int DW = 8;
    // Configuration bus widths.
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Register word index, taken from paddr[APB_AW-1:2].
    localparam logic [APB_AW-3:0] REG_SIZE_IN_USE = '0;
    localparam logic [SW-1:0]     SIZE_RESET      = 11'd1024;

    typedef enum logic [2:0] {
        REQ_PUT     = 3'd0,
        REQ_GET     = 3'd1,
        REQ_COMMIT  = 3'd2,
        REQ_DISCARD = 3'd3,
        REQ_PEEK    = 3'd4,
        REQ_POKE    = 3'd5,
        REQ_STATUS  = 3'd6,
        REQ_CLEAR   = 3'd7
    } t_req_type;

    typedef struct packed {
        t_req_type       req_type;
        logic [DW-1:0]   data_in;
        logic [SW-1:0]   amount;
    } t_bfifo_req;

    typedef struct packed {
        logic [DW-1:0]   rd_data;
        logic [SW-1:0]   accepted;
        logic            ok;
        logic [SW-1:0]   fill_level;
        logic [SW-1:0]   free_space;
        logic            is_empty;
        logic            is_full;
    } t_bfifo_rsp;

endpackage

### rtl/core/bfifo_chan_if.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO channel interface
// Valid/ready channel carrying one payload item of a chosen type.
// ----------------------------------------------------------------------------
interface bfifo_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/byte_ring_fifo_top.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO top level
// Ring buffer of bytes with put, get, commit, discard, peek, poke, status
// and clear requests, and an APB-style register for the size in use.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  i_req     in         valid/ready          req_type, data_in, amount
//  o_rsp     out        valid/ready          rd_data, accepted, ok,
//                                            fill_level, free_space,
//                                            is_empty, is_full
//  APB       in/out     psel/penable/pready  size_in_use at byte address 0
//
// For every request, the indices, the fill count and the RAM access are
// handled in the accept cycle, and the result register (with the RAM read
// register for rd_data) presents the answer on the next cycle.
// A new request is taken in every cycle while the result side keeps up; the
// single result register is the only buffer, so a stalled result holds off
// the next request. Reset clears the indices, the fill count and the result
// valid and sets the size to 1024. The storage is not cleared.
//
`include "byte_ring_fifo_top_defines.svh"

module byte_ring_fifo_top
    import bfifo_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bfifo_chan_if.sink          i_req,
    bfifo_chan_if.source        o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Index width follows the storage depth. Arithmetic on indices runs one
    // bit wider than either an index or a length so that a sum never wraps.
    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = ((IW > SW) ? IW : SW) + 1;
    // The largest usable size is bounded by both the storage and the field.
    localparam int SMAX = (DEPTH > ((1 << SW) - 1)) ? ((1 << SW) - 1) : DEPTH;

    // Adds a step to an index; both are below the size, so a single
    // subtraction brings the sum back into the ring.
    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] base,
                                             input logic [SW-1:0] step,
                                             input logic [SW-1:0] size);
        logic [CW-1:0] sum;
        sum = CW'(base) + CW'(step);
        if (sum >= CW'(size)) begin
            sum = sum - CW'(size);
        end
        return sum[IW-1:0];
    endfunction

    // Architectural state.
    logic [SW-1:0] r_size;
    logic [IW-1:0] r_widx, n_widx;
    logic [IW-1:0] r_ridx, n_ridx;
    logic [SW-1:0] r_fill, n_fill;

    // Result stage.
    logic          r_out_valid;
    t_bfifo_rsp    r_rsp, n_rsp;
    logic          r_rd_sel, n_rd_sel;

    // Request datapath.
    t_bfifo_req    w_req;
    logic          w_fire;
    logic          w_cfg_wr;
    logic [SW-1:0] w_size;
    logic [SW-1:0] w_free;
    logic [SW-1:0] w_commit_n;
    logic [SW-1:0] w_discard_n;
    logic [SW-1:0] w_wr_step;
    logic [SW-1:0] w_rd_step;
    logic [IW-1:0] w_wr_sum;
    logic [IW-1:0] w_rd_sum;
    logic [SW-1:0] w_free_next;

    // RAM port.
    logic          w_ram_we;
    logic [IW-1:0] w_ram_addr;
    logic [DW-1:0] w_ram_rdata;

    assign w_req  = i_req.data;
    assign w_fire = i_req.valid && i_req.ready;

    // The result register is the only buffer: take a request whenever it is
    // empty or is being drained in the same cycle.
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so there are never wait states.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[APB_AW-1:2] == REG_SIZE_IN_USE);

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_SIZE_IN_USE) begin
            prdata = APB_DW'(r_size);
        end
    end

    // A size of zero behaves as one, and anything above the storage as the
    // whole storage.
    always_comb begin
        if (r_size == '0) begin
            w_size = SW'(1);
        end else if (r_size > SW'(SMAX)) begin
            w_size = SW'(SMAX);
        end else begin
            w_size = r_size;
        end
    end

    assign w_free      = w_size - r_fill;
    assign w_commit_n  = (w_req.amount < w_free) ? w_req.amount : w_free;
    assign w_discard_n = (r_fill < w_req.amount) ? r_fill : w_req.amount;

    // One wrap adder per index. A run that covers the whole ring leaves the
    // index where it is.
    always_comb begin
        case (w_req.req_type)
            REQ_PUT:    w_wr_step = SW'(1);
            REQ_COMMIT: w_wr_step = (w_commit_n == w_size) ? '0 : w_commit_n;
            default:    w_wr_step = w_req.amount;
        endcase
        case (w_req.req_type)
            REQ_GET:     w_rd_step = SW'(1);
            REQ_DISCARD: w_rd_step = (w_discard_n == w_size) ? '0 : w_discard_n;
            default:     w_rd_step = w_req.amount;
        endcase
    end

    assign w_wr_sum = f_wrap(r_widx, w_wr_step, w_size);
    assign w_rd_sum = f_wrap(r_ridx, w_rd_step, w_size);

    // Request decode: next state, RAM access and result fields.
    always_comb begin
        n_widx     = r_widx;
        n_ridx     = r_ridx;
        n_fill     = r_fill;
        n_rd_sel   = 1'b0;
        w_ram_we   = 1'b0;
        w_ram_addr = r_ridx;
        n_rsp      = '0;

        unique case (w_req.req_type)
            REQ_PUT: begin
                w_ram_addr = r_widx;
                if (w_free != '0) begin
                    w_ram_we       = w_fire;
                    n_widx         = w_wr_sum;
                    n_fill         = r_fill + SW'(1);
                    n_rsp.accepted = SW'(1);
                    n_rsp.ok       = 1'b1;
                end
            end
            REQ_GET: begin
                if (r_fill != '0) begin
                    n_rd_sel       = 1'b1;
                    n_ridx         = w_rd_sum;
                    n_fill         = r_fill - SW'(1);
                    n_rsp.accepted = SW'(1);
                    n_rsp.ok       = 1'b1;
                end
            end
            REQ_COMMIT: begin
                n_widx         = w_wr_sum;
                n_fill         = r_fill + w_commit_n;
                n_rsp.accepted = w_commit_n;
                n_rsp.ok       = 1'b1;
            end
            REQ_DISCARD: begin
                n_ridx         = w_rd_sum;
                n_fill         = r_fill - w_discard_n;
                n_rsp.accepted = w_discard_n;
                n_rsp.ok       = 1'b1;
            end
            REQ_PEEK: begin
                w_ram_addr = w_rd_sum;
                if (w_req.amount < r_fill) begin
                    n_rd_sel = 1'b1;
                    n_rsp.ok = 1'b1;
                end
            end
            REQ_POKE: begin
                w_ram_addr = w_wr_sum;
                if (w_req.amount < w_free) begin
                    w_ram_we = w_fire;
                    n_rsp.ok = 1'b1;
                end
            end
            REQ_STATUS: begin
                n_rsp.ok = 1'b1;
            end
            REQ_CLEAR: begin
                n_widx   = '0;
                n_ridx   = '0;
                n_fill   = '0;
                n_rsp.ok = 1'b1;
            end
        endcase

        w_free_next      = w_size - n_fill;
        n_rsp.fill_level = n_fill;
        n_rsp.free_space = w_free_next;
        n_rsp.is_empty   = (n_fill == '0);
        n_rsp.is_full    = (w_free_next == '0);
    end

    // State registers. A size write restarts the ring; the stored bytes
    // stay in place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_widx <= '0;
            r_ridx <= '0;
            r_fill <= '0;
        end else if (w_cfg_wr) begin
            r_size <= pwdata[SW-1:0];
            r_widx <= '0;
            r_ridx <= '0;
            r_fill <= '0;
        end else if (w_fire) begin
            r_widx <= n_widx;
            r_ridx <= n_ridx;
            r_fill <= n_fill;
        end
    end

    // Result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded together with the RAM read register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp    <= n_rsp;
            r_rd_sel <= n_rd_sel;
        end
    end

    bfifo_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_fire),
        .i_addr  (w_ram_addr),
        .i_wdata (w_req.data_in),
        .o_rdata (w_ram_rdata)
    );

    // Only a successful get or peek shows the stored byte.
    always_comb begin
        o_rsp.data         = r_rsp;
        o_rsp.data.rd_data = r_rd_sel ? w_ram_rdata : '0;
    end
    assign o_rsp.valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BFIFO_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= w_size, "fill above size")
    `BFIFO_ASSERT_SAME(a_stall_blocks, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, !i_req.ready, "request taken while result stalled")
    `BFIFO_ASSERT_NEXT(a_fire_result, i_clk, i_rst_n, w_fire, o_rsp.valid, "accepted request gave no result")

endmodule

### rtl/core/bfifo_ram.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO storage RAM
// Single-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // The read register holds its value while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sim/tb_byte_ring_fifo_top.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO testbench
// Drives put, get, commit, discard, peek, poke, status and clear requests
// into the ring under several ring sizes and handshake idling patterns, and
// compares every response with a cycle-free model of the ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package tb_bfifo_pkg;
    import bfifo_pkg::*;

    localparam int RING_DEPTH = 1024;

    // Tracks the ring contents, indices and fill count as requests are
    // accepted, and holds the responses they must produce, oldest first.
    class bfifo_ring_tracker;
        bit [DW-1:0]  ring_bytes   [RING_DEPTH];
        bit           ring_written [RING_DEPTH];
        int unsigned  wr_pos;
        int unsigned  rd_pos;
        int unsigned  held;
        int unsigned  size_reg;
        t_bfifo_rsp   expected_rsp [$];
        int unsigned  failures;
        int unsigned  checked;
        int unsigned  refused;
        int unsigned  full_hits;
        int unsigned  empty_hits;

        function new();
            size_reg = 32'(SIZE_RESET);
        endfunction

        function int unsigned ring_size();
            int unsigned s;
            s = size_reg;
            if (s == 0)
                s = 1;
            if (s > RING_DEPTH)
                s = RING_DEPTH;
            return s;
        endfunction

        // Both operands are below s, so one subtraction wraps the sum.
        function int unsigned wrap(int unsigned base, int unsigned step, int unsigned s);
            int unsigned v;
            v = base + step;
            if (v >= s)
                v -= s;
            return v;
        endfunction

        // A size write also empties the ring; the stored bytes stay.
        function void set_size(int unsigned value);
            size_reg = value & 'h7FF;
            wr_pos   = 0;
            rd_pos   = 0;
            held     = 0;
        endfunction

        // Storage is undefined until written, so a get or peek that would
        // land on a never-written byte is turned into a harmless request.
        function t_bfifo_req legalize(t_bfifo_req r);
            t_bfifo_req item;
            item = r;
            if (item.req_type == REQ_GET && held != 0 && !ring_written[rd_pos])
                item.req_type = REQ_PUT;
            if (item.req_type == REQ_PEEK && item.amount < held &&
                !ring_written[wrap(rd_pos, 32'(item.amount), ring_size())])
                item.amount = SW'(held);
            return item;
        endfunction

        function void note_request(t_bfifo_req r);
            t_bfifo_rsp  e;
            int unsigned s;
            int unsigned amt;
            int unsigned n;
            int unsigned room;
            int unsigned idx;
            s   = ring_size();
            amt = 32'(r.amount);
            e   = '0;
            if (held > s)
                held = s;
            if (wr_pos >= s)
                wr_pos = 0;
            if (rd_pos >= s)
                rd_pos = 0;
            room = s - held;
            case (r.req_type)
                REQ_PUT: begin
                    if (room != 0) begin
                        ring_bytes[wr_pos]   = r.data_in;
                        ring_written[wr_pos] = 1'b1;
                        wr_pos     = wrap(wr_pos, 1, s);
                        held++;
                        e.accepted = SW'(1);
                        e.ok       = 1'b1;
                    end
                end
                REQ_GET: begin
                    if (held != 0) begin
                        e.rd_data  = ring_bytes[rd_pos];
                        rd_pos     = wrap(rd_pos, 1, s);
                        held--;
                        e.accepted = SW'(1);
                        e.ok       = 1'b1;
                    end
                end
                REQ_COMMIT: begin
                    n          = (amt < room) ? amt : room;
                    wr_pos     = wrap(wr_pos, (n == s) ? 0 : n, s);
                    held      += n;
                    e.accepted = SW'(n);
                    e.ok       = 1'b1;
                end
                REQ_DISCARD: begin
                    n          = (amt < held) ? amt : held;
                    rd_pos     = wrap(rd_pos, (n == s) ? 0 : n, s);
                    held      -= n;
                    e.accepted = SW'(n);
                    e.ok       = 1'b1;
                end
                REQ_PEEK: begin
                    if (amt < held) begin
                        e.rd_data = ring_bytes[wrap(rd_pos, amt, s)];
                        e.ok      = 1'b1;
                    end
                end
                REQ_POKE: begin
                    if (amt < room) begin
                        idx               = wrap(wr_pos, amt, s);
                        ring_bytes[idx]   = r.data_in;
                        ring_written[idx] = 1'b1;
                        e.ok              = 1'b1;
                    end
                end
                REQ_STATUS: begin
                    e.ok = 1'b1;
                end
                REQ_CLEAR: begin
                    wr_pos = 0;
                    rd_pos = 0;
                    held   = 0;
                    e.ok   = 1'b1;
                end
            endcase
            room         = s - held;
            e.fill_level = SW'(held);
            e.free_space = SW'(room);
            e.is_empty   = (held == 0);
            e.is_full    = (room == 0);
            if (!e.ok)
                refused++;
            if (e.is_full)
                full_hits++;
            if (e.is_empty)
                empty_hits++;
            expected_rsp.push_back(e);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                failures++;
            end
        endfunction

        function void check_response(t_bfifo_rsp r);
            t_bfifo_rsp e;
            if (expected_rsp.size() == 0) begin
                $error("response with no request waiting");
                failures++;
                return;
            end
            e = expected_rsp.pop_front();
            checked++;
            compare_field("rd_data",    16'(e.rd_data),    16'(r.rd_data));
            compare_field("accepted",   16'(e.accepted),   16'(r.accepted));
            compare_field("ok",         16'(e.ok),         16'(r.ok));
            compare_field("fill_level", 16'(e.fill_level), 16'(r.fill_level));
            compare_field("free_space", 16'(e.free_space), 16'(r.free_space));
            compare_field("is_empty",   16'(e.is_empty),   16'(r.is_empty));
            compare_field("is_full",    16'(e.is_full),    16'(r.is_full));
        endfunction

        function int unsigned waiting();
            return expected_rsp.size();
        endfunction
    endclass

endpackage

module tb_byte_ring_fifo_top;
    import bfifo_pkg::*;
    import tb_bfifo_pkg::*;

    // Ring sizes of the random phases, the extremes and the out-of-range
    // encodings among them. Zero acts as one and anything above the depth
    // acts as the depth.
    localparam int NUM_PHASES       = 10;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int RSP_STALL_CYCLES = 300;
    localparam int STALL_AT_ITEM    = 40;
    localparam logic [APB_AW-1:0] SIZE_ADDR = {REG_SIZE_IN_USE, 2'b00};
    localparam int unsigned PHASE_SIZE [NUM_PHASES] =
        '{1, 3, 0, 16, 2, 1024, 7, 2047, 1023, 5};

    logic i_clk = 1'b0;
    logic i_rst_n;

    // APB configuration port.
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bfifo_chan_if #(.T(t_bfifo_req)) req_if ();
    bfifo_chan_if #(.T(t_bfifo_rsp)) rsp_if ();

    byte_ring_fifo_top #(
        .DEPTH   (RING_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bfifo_ring_tracker tracker;

    // Percent of cycles in which each side holds off.
    int unsigned send_idle_pct = 0;
    int unsigned rsp_idle_pct  = 0;

    // The main thread bumps the stall token to ask the response side for a
    // long hold-off; the count itself runs in its own process below.
    int unsigned stall_token = 0;
    int unsigned stall_seen  = 0;
    int unsigned stall_left  = 0;

    int unsigned apb_errors  = 0;
    int unsigned sizes_run   = 0;

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Response side. The hold-off counter moves on rising edges, and ready
    // changes on falling edges so that it is stable whenever it is sampled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_token != stall_seen) begin
            stall_seen <= stall_token;
            stall_left <= RSP_STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= (stall_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. A response accepted at this edge always belongs to a request
    // taken at an earlier edge, so it is checked before the new request is
    // noted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (rsp_if.valid && rsp_if.ready)
                tracker.check_response(rsp_if.data);
            if (req_if.valid && req_if.ready)
                tracker.note_request(req_if.data);
        end
    end

    // ------------------------------------------------------------------------
    // Request driving. The item is legalized against the ring state as it
    // stands after the previous request was taken, then offered after a
    // random number of idle cycles. Valid stays high into the next item
    // when no idle cycle follows, so it gets one assignment per step.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_bfifo_req r);
        t_bfifo_req item;
        item = tracker.legalize(r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_bfifo_req make_req(input t_req_type kind, input logic [DW-1:0] data,
                                            input int unsigned amt);
        t_bfifo_req r;
        r.req_type = kind;
        r.data_in  = data;
        r.amount   = SW'(amt);
        return r;
    endfunction

    // Random request. Offsets and lengths mostly fall around the fill level
    // or the free space, where the clamping and the bounds checks change
    // the answer; the rest covers zero, the full 11-bit range and its top.
    function automatic t_bfifo_req random_request();
        t_bfifo_req  r;
        int unsigned pick;
        int unsigned reach;
        int unsigned room;
        int unsigned amt;
        room = tracker.ring_size() - tracker.held;
        pick = $urandom_range(99);
        if (pick < 22)
            r.req_type = REQ_PUT;
        else if (pick < 44)
            r.req_type = REQ_GET;
        else if (pick < 54)
            r.req_type = REQ_COMMIT;
        else if (pick < 62)
            r.req_type = REQ_DISCARD;
        else if (pick < 74)
            r.req_type = REQ_PEEK;
        else if (pick < 88)
            r.req_type = REQ_POKE;
        else if (pick < 94)
            r.req_type = REQ_STATUS;
        else
            r.req_type = REQ_CLEAR;
        r.data_in = DW'($urandom_range(255));
        if (r.req_type == REQ_PEEK || r.req_type == REQ_DISCARD)
            reach = tracker.held;
        else
            reach = room;
        case ($urandom_range(9))
            0:       amt = 0;
            6:       amt = reach + $urandom_range(2);
            7:       amt = $urandom_range(2047);
            8:       amt = 2047;
            9:       amt = 1024;
            default: amt = $urandom_range(reach);
        endcase
        r.amount = SW'(amt);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // APB access. A read checks that the size register gives back what was
    // last written; a write updates the model at the access edge and is then
    // read back.
    // ------------------------------------------------------------------------
    task automatic apb_read_size(input logic [SW-1:0] expected);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SIZE_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[SW-1:0] !== expected) begin
            $error("size_in_use mismatch: expected %0d, actual %0d", expected,
                   prdata[SW-1:0]);
            apb_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_write_size(input logic [SW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        tracker.set_size(32'(value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apb_read_size(value);
        sizes_run++;
    endtask

    // The sender stops and waits for every outstanding response, so the
    // block is idle before the size register is touched.
    task automatic drain_responses();
        while (tracker.waiting() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Generous bound on the whole run.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        tracker      = new();
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // The size register must come out of reset at its full value.
        apb_read_size(SIZE_RESET);

        // Directed part on a three-byte ring: empty and full edges, a put
        // that is dropped, reads past the fill level, pokes past the free
        // space, commit and discard of zero and clamped lengths, wrap-around
        // of both indices, and clear.
        send_idle_pct = 31;
        rsp_idle_pct  = 81;
        apb_write_size(SW'(3));
        send_request(make_req(REQ_STATUS,  8'h00, 0));
        send_request(make_req(REQ_GET,     8'h00, 0));
        send_request(make_req(REQ_PEEK,    8'h00, 0));
        send_request(make_req(REQ_DISCARD, 8'h00, 5));
        send_request(make_req(REQ_PUT,     8'h00, 0));
        send_request(make_req(REQ_PUT,     8'hFF, 2047));
        send_request(make_req(REQ_PUT,     8'hA5, 0));
        send_request(make_req(REQ_PUT,     8'h5A, 0));
        send_request(make_req(REQ_PEEK,    8'h00, 0));
        send_request(make_req(REQ_PEEK,    8'h00, 2));
        send_request(make_req(REQ_PEEK,    8'h00, 3));
        send_request(make_req(REQ_POKE,    8'h11, 0));
        send_request(make_req(REQ_GET,     8'h00, 0));
        send_request(make_req(REQ_GET,     8'h00, 0));
        send_request(make_req(REQ_POKE,    8'h3C, 0));
        send_request(make_req(REQ_POKE,    8'hC3, 1));
        send_request(make_req(REQ_POKE,    8'h99, 2));
        send_request(make_req(REQ_COMMIT,  8'h00, 0));
        send_request(make_req(REQ_COMMIT,  8'h00, 2047));
        send_request(make_req(REQ_DISCARD, 8'h00, 0));
        send_request(make_req(REQ_DISCARD, 8'h00, 1));
        send_request(make_req(REQ_PEEK,    8'h00, 1));
        send_request(make_req(REQ_GET,     8'h00, 1024));
        send_request(make_req(REQ_CLEAR,   8'h00, 0));
        send_request(make_req(REQ_STATUS,  8'h00, 0));
        req_if.valid <= 1'b0;
        drain_responses();

        // Random phases, one ring size each. The first four starve the
        // response side, the next three starve the request side, and the
        // last three run both sides flat out.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 31 : (ph < 7) ? 81 : 0;
            rsp_idle_pct  = (ph < 4) ? 81 : (ph < 7) ? 31 : 0;
            apb_write_size(SW'(PHASE_SIZE[ph]));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Hold the response side off while requests keep coming, so
                // the single result register fills and blocks new requests.
                if (k == STALL_AT_ITEM && (ph == 1 || ph == 8))
                    stall_token++;
                send_request(random_request());
            end
            req_if.valid <= 1'b0;
            drain_responses();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.waiting() != 0)
            $error("%0d responses never arrived", tracker.waiting());
        $display("Checked %0d responses over %0d ring size settings.", tracker.checked,
                 sizes_run);
        $display("Saw %0d refused requests, %0d full and %0d empty results.",
                 tracker.refused, tracker.full_hits, tracker.empty_hits);
        if (tracker.failures == 0 && apb_errors == 0 && tracker.waiting() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
